// ----- rtl/spab_pkg.sv -----
// ----------------------------------------------------------------------------
// spab_pkg
// Shared types, constants and the microcode program of the speed PID core.
// ----------------------------------------------------------------------------
package spab_pkg;

  // Field and datapath widths.
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int INTEG_W = 21;
  localparam int D50_W   = 24;
  localparam int OPA_W   = 24;
  localparam int OPB_W   = 16;
  localparam int PROD_W  = 40;
  localparam int ACC_W   = 42;
  localparam int CMD_W   = 13;
  localparam int STEP_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Arithmetic constants.
  localparam logic signed [OPB_W-1:0]   INTEG_STEP  = 16'sd1311;   // 0.02 in Q.16
  localparam logic signed [OPB_W-1:0]   DERIV_RATE  = 16'sd50;     // 1 / 0.02 s
  localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 21'sd655360; // 10.0 in Q.16
  localparam logic [CMD_W-1:0]          CMD_MAX     = 13'd4096;    // 1.0 in Q1.12

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

  // Program steps.
  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] ST_INC   = 3'd1;
  localparam logic [STEP_W-1:0] ST_INTEG = 3'd2;
  localparam logic [STEP_W-1:0] ST_PROP  = 3'd3;
  localparam logic [STEP_W-1:0] ST_RATE  = 3'd4;
  localparam logic [STEP_W-1:0] ST_ITERM = 3'd5;
  localparam logic [STEP_W-1:0] ST_DTERM = 3'd6;
  localparam logic [STEP_W-1:0] ST_OUT   = 3'd7;

  // Jump condition: when true the sequencer goes to the target step.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_IN,
    COND_OUT_BUSY
  } cond_t;

  // Multiplier operand A select.
  typedef enum logic [1:0] {
    MA_ERR,
    MA_DIFF,
    MA_INTEG,
    MA_D50
  } mula_t;

  // Multiplier operand B select.
  typedef enum logic [2:0] {
    MB_STEP,
    MB_RATE,
    MB_KP,
    MB_KI,
    MB_KD
  } mulb_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SHR
  } acc_op_t;

  // One control word of the program.
  typedef struct packed {
    logic              take_in;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              mul_en;
    mula_t             mula;
    mulb_t             mulb;
    acc_op_t           acc_op;
    logic              diff_load;
    logic              integ_load;
    logic              d50_load;
    logic              out_load;
  } ctrl_t;

  // Status seen by the sequencer for its jumps.
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } stat_t;

  // Microcode table: one control word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '0;
    unique case (step)
      ST_IDLE: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_NO_IN;
        cw.target  = ST_IDLE;
      end
      ST_INC: begin
        cw.mul_en    = 1'b1;
        cw.mula      = MA_ERR;
        cw.mulb      = MB_STEP;
        cw.diff_load = 1'b1;
      end
      ST_INTEG: begin
        cw.integ_load = 1'b1;
        cw.mul_en     = 1'b1;
        cw.mula       = MA_ERR;
        cw.mulb       = MB_KP;
      end
      ST_PROP: begin
        cw.acc_op = ACC_LOAD;
        cw.mul_en = 1'b1;
        cw.mula   = MA_DIFF;
        cw.mulb   = MB_RATE;
      end
      ST_RATE: begin
        cw.d50_load = 1'b1;
        cw.mul_en   = 1'b1;
        cw.mula     = MA_INTEG;
        cw.mulb     = MB_KI;
      end
      ST_ITERM: begin
        cw.acc_op = ACC_ADD_SHR;
        cw.mul_en = 1'b1;
        cw.mula   = MA_D50;
        cw.mulb   = MB_KD;
      end
      ST_DTERM: begin
        cw.acc_op = ACC_ADD;
      end
      ST_OUT: begin
        cw.out_load = 1'b1;
        cw.cond     = COND_OUT_BUSY;
        cw.target   = ST_OUT;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/spab_seq.sv -----
// ----------------------------------------------------------------------------
// spab_seq
// Step counter with conditional jumps; reads the control word of each step.
// ----------------------------------------------------------------------------
module spab_seq
  import spab_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  stat_t             stat,
  output ctrl_t             cw,
  output logic [STEP_W-1:0] step
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              jump;

  // Control word of the current step.
  assign cw   = ucode(step_r);
  assign step = step_r;

  // Jump decision and next step; the last step wraps to the first.
  always_comb begin
    unique case (cw.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_IN:    jump = !stat.in_valid;
      COND_OUT_BUSY: jump = stat.out_busy;
      default:       jump = 1'b0;
    endcase
    step_nxt = jump ? cw.target : step_r + STEP_W'(1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- rtl/spab_dp.sv -----
// ----------------------------------------------------------------------------
// spab_dp
// PID datapath: one shared signed multiplier, error and integral state, and
// the accumulator with the throttle and brake saturation.
// ----------------------------------------------------------------------------
module spab_dp
  import spab_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_t                     cw,
  input  logic                      in_fire,
  input  logic signed [SPEED_W-1:0] meas,
  input  logic signed [SPEED_W-1:0] targ,
  input  logic signed [GAIN_W-1:0]  kp,
  input  logic signed [GAIN_W-1:0]  ki,
  input  logic signed [GAIN_W-1:0]  kd,
  output logic [CMD_W-1:0]          accel,
  output logic [CMD_W-1:0]          brake
);

  logic signed [ERR_W-1:0]   err_r;
  logic signed [DIFF_W-1:0]  last_err_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [D50_W-1:0]   d50_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic signed [OPA_W-1:0]   opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_shr;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [DIFF_W-1:0]  diff;
  logic                      pos;
  logic [ACC_W:0]            mag_full;
  logic [ACC_W-4:0]          mag;
  logic [CMD_W-1:0]          mag_sat;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cw.mula)
      MA_ERR:   opa = OPA_W'(err_r);
      MA_DIFF:  opa = OPA_W'(diff_r);
      MA_INTEG: opa = OPA_W'(integ_r);
      MA_D50:   opa = OPA_W'(d50_r);
      default:  opa = '0;
    endcase
    unique case (cw.mulb)
      MB_STEP: opb = INTEG_STEP;
      MB_RATE: opb = DERIV_RATE;
      MB_KP:   opb = kp;
      MB_KI:   opb = ki;
      MB_KD:   opb = kd;
      default: opb = '0;
    endcase
  end

  assign prod     = PROD_W'(opa) * PROD_W'(opb);
  assign prod_shr = prod_r >>> 8;

  // Integral update with clamp to plus or minus ten.
  always_comb begin
    integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(prod_shr);
    if (integ_sum > (INTEG_W+1)'(INTEG_LIMIT)) begin
      integ_nxt = INTEG_LIMIT;
    end else if (integ_sum < -(INTEG_W+1)'(INTEG_LIMIT)) begin
      integ_nxt = -INTEG_LIMIT;
    end else begin
      integ_nxt = INTEG_W'(integ_sum);
    end
  end

  assign diff = DIFF_W'(err_r) - last_err_r;

  // Controller state: previous error and integral.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integ_r    <= '0;
    end else begin
      if (cw.diff_load) begin
        last_err_r <= DIFF_W'(err_r);
      end
      if (cw.integ_load) begin
        integ_r <= integ_nxt;
      end
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r <= ERR_W'(targ) - ERR_W'(meas);
    end
    if (cw.diff_load) begin
      diff_r <= diff;
    end
    if (cw.d50_load) begin
      d50_r <= prod_r[D50_W-1:0];
    end
    if (cw.mul_en) begin
      prod_r <= prod;
    end
    unique case (cw.acc_op)
      ACC_HOLD:    acc_r <= acc_r;
      ACC_LOAD:    acc_r <= ACC_W'(prod_r);
      ACC_ADD:     acc_r <= acc_r + ACC_W'(prod_r);
      ACC_ADD_SHR: acc_r <= acc_r + ACC_W'(prod_shr);
      default:     acc_r <= acc_r;
    endcase
  end

  // Split the sum into throttle or brake, each saturated at one.
  always_comb begin
    pos      = (acc_r > 0);
    mag_full = pos ? (ACC_W+1)'(acc_r) : -(ACC_W+1)'(acc_r);
    mag      = mag_full[ACC_W:4];
    mag_sat  = (mag > (ACC_W-3)'(CMD_MAX)) ? CMD_MAX : mag[CMD_W-1:0];
    accel    = pos ? mag_sat : '0;
    brake    = pos ? '0 : mag_sat;
  end

endmodule

// ----- rtl/speed_pid_accel_brake_core.sv -----
// ----------------------------------------------------------------------------
// speed_pid_accel_brake_core
// Velocity PID regulator producing throttle and brake commands.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item carries a measured and a target speed (signed Q7.8).
//   The block answers every item with one result item holding accel_cmd
//   and brake_cmd (Q1.12, 4096 is full scale); at most one is nonzero.
//   Input and output use valid/stall handshakes; an item moves on a clock
//   edge where valid is high and stall is low.
//   A microcoded sequencer runs an eight-step program over one shared
//   16 x 24 multiplier. An item is taken in the first step and its result
//   is loaded into the output register in the last step. A new item is
//   accepted only once the program has wrapped back to its first step.
//   If the receiver stalls, the result waits in the output register; the
//   next item is still accepted and runs until its own result is due, then
//   the sequencer holds in its last step until the register frees up.
//   Gains are written through cfg_we/cfg_index/cfg_wdata; the user must
//   write them only while idle, as the block does not enforce it. Synchronous
//   reset clears the gains, the integral, the last error, the output valid
//   and returns the program to its first step.
module speed_pid_accel_brake_core
  import spab_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [GAIN_W-1:0]         cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SPEED_W-1:0] in_measured_speed,
  input  logic signed [SPEED_W-1:0] in_target_speed,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CMD_W-1:0]          out_accel_cmd,
  output logic [CMD_W-1:0]          out_brake_cmd
);

  logic signed [GAIN_W-1:0] prop_gain_r;
  logic signed [GAIN_W-1:0] integ_gain_r;
  logic signed [GAIN_W-1:0] deriv_gain_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [CMD_W-1:0]         out_accel_r;
  logic [CMD_W-1:0]         out_brake_r;

  ctrl_t             cw;
  stat_t             stat;
  logic [STEP_W-1:0] step;
  logic              in_fire;
  logic              out_load;
  logic [CMD_W-1:0]  accel;
  logic [CMD_W-1:0]  brake;

  // Handshake control.
  assign in_stall      = !cw.take_in;
  assign in_fire       = in_valid && cw.take_in;
  assign stat.in_valid = in_valid;
  assign stat.out_busy = out_valid_r && out_stall;
  assign out_load      = cw.out_load && !stat.out_busy;

  // Gain registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
        REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  spab_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw),
    .step  (step)
  );

  spab_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cw      (cw),
    .in_fire (in_fire),
    .meas    (in_measured_speed),
    .targ    (in_target_speed),
    .kp      (prop_gain_r),
    .ki      (integ_gain_r),
    .kd      (deriv_gain_r),
    .accel   (accel),
    .brake   (brake)
  );

  // Output register valid.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_accel_r <= accel;
      out_brake_r <= brake;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_accel_cmd = out_accel_r;
  assign out_brake_cmd = out_brake_r;

`ifndef SYNTH
  // An accepted item starts the program.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> step == ST_INC)
    else $error("program did not advance after an accepted item");

  // A new result is only loaded from the last step.
  a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> step == ST_OUT)
    else $error("result loaded outside the output step");

  // Throttle and brake are never both applied.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_accel_r == '0 || out_brake_r == '0))
    else $error("throttle and brake both nonzero");

  // Commands stay within full scale.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_accel_r <= CMD_MAX && out_brake_r <= CMD_MAX))
    else $error("command beyond full scale");
`endif

endmodule

// ----- bench/speed_pid_accel_brake_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speed_pid_accel_brake_core_tb
// Self-checking bench for the speed PID core: a queue-fed driver offers speed
// items, a bit-exact PID predictor computes the throttle and brake command for
// each accepted item, and a monitor compares every result item with the
// oldest prediction. Gains are changed only between phases, once idle.
// ----------------------------------------------------------------------------
module speed_pid_accel_brake_core_tb;
  import spab_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CORE_LATENCY = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 240;
  // Index past the last gain register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SPEED_W-1:0] meas;
    logic signed [SPEED_W-1:0] targ;
  } speed_item_t;

  typedef struct packed {
    logic [CMD_W-1:0] accel;
    logic [CMD_W-1:0] brake;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SPEED_W-1:0] in_measured_speed = '0;
  logic signed [SPEED_W-1:0] in_target_speed = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CMD_W-1:0] out_accel_cmd;
  logic [CMD_W-1:0] out_brake_cmd;

  // Pending speed items and predicted commands.
  speed_item_t speed_q[$];
  cmd_t want_cmd_q[$];

  // Predictor copy of the gains and the loop state.
  logic signed [GAIN_W-1:0]  kp_q = '0;
  logic signed [GAIN_W-1:0]  ki_q = '0;
  logic signed [GAIN_W-1:0]  kd_q = '0;
  logic signed [DIFF_W-1:0]  last_err_q = '0;
  logic signed [INTEG_W-1:0] integ_q = '0;

  int   fail_cnt = 0;
  logic in_taken = 1'b0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   send_gap = 0;
  int   recv_gap = 0;

  speed_pid_accel_brake_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_measured_speed (in_measured_speed),
    .in_target_speed   (in_target_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accel_cmd     (out_accel_cmd),
    .out_brake_cmd     (out_brake_cmd)
  );

  always #(CLK_HALF) clk = ~clk;

  // Advance the PID state by one item and return the command it produces.
  function automatic cmd_t pid_predict(input logic signed [SPEED_W-1:0] meas,
                                       input logic signed [SPEED_W-1:0] targ);
    longint err;
    longint integ;
    longint p_term;
    longint i_term;
    longint d_term;
    longint total;
    longint mag;
    cmd_t cmd;
    err = longint'(targ) - longint'(meas);
    integ = longint'(integ_q) + ((err * longint'(INTEG_STEP)) >>> 8);
    if (integ > longint'(INTEG_LIMIT)) integ = longint'(INTEG_LIMIT);
    if (integ < -longint'(INTEG_LIMIT)) integ = -longint'(INTEG_LIMIT);
    integ_q = integ[INTEG_W-1:0];
    p_term = longint'(kp_q) * err;
    i_term = (longint'(ki_q) * integ) >>> 8;
    d_term = longint'(kd_q) * ((err - longint'(last_err_q)) * longint'(DERIV_RATE));
    last_err_q = err[DIFF_W-1:0];
    total = p_term + i_term + d_term;
    cmd = '0;
    // A positive sum drives the throttle, anything else the brake.
    if (total > 0) begin
      mag = total >>> 4;
      cmd.accel = (mag > longint'(CMD_MAX)) ? CMD_MAX : mag[CMD_W-1:0];
    end else begin
      mag = (-total) >>> 4;
      cmd.brake = (mag > longint'(CMD_MAX)) ? CMD_MAX : mag[CMD_W-1:0];
    end
    return cmd;
  endfunction

  function automatic void add_item(input int meas, input int targ);
    speed_item_t it;
    it.meas = meas[SPEED_W-1:0];
    it.targ = targ[SPEED_W-1:0];
    speed_q = {speed_q, it};
  endfunction

  // Mostly a measured speed close to its target, sometimes raw noise.
  function automatic void add_random_item();
    int t;
    int dlt;
    if ($urandom_range(0, 4) == 0) begin
      add_item(int'($urandom), int'($urandom));
    end else begin
      t = int'($urandom_range(0, 16384)) - 8192;
      dlt = int'($urandom_range(0, 2048)) - 1024;
      add_item(t + dlt, t);
    end
  endfunction

  // A gain that is usually modest, now and then anywhere in range.
  function automatic logic [GAIN_W-1:0] pick_gain(input int span);
    int g;
    if ($urandom_range(0, 3) == 0) begin
      g = int'($urandom);
    end else begin
      g = int'($urandom_range(0, 2 * span)) - span;
    end
    return g[GAIN_W-1:0];
  endfunction

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx,
                            input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_PROP_GAIN) kp_q = val;
    else if (idx == REG_INTEG_GAIN) ki_q = val;
    else if (idx == REG_DERIV_GAIN) kd_q = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd);
    write_gain(REG_PROP_GAIN, kp);
    write_gain(REG_INTEG_GAIN, ki);
    write_gain(REG_DERIV_GAIN, kd);
  endtask

  // Wait until every offered item has come back, then let the core settle.
  task automatic wait_idle();
    while (speed_q.size() != 0 || in_valid || want_cmd_q.size() != 0) @(posedge clk);
    repeat (CORE_LATENCY + 4) @(negedge clk);
  endtask

  // Driver: present the next queued item, with random gaps between items.
  always @(negedge clk) begin : drive_items
    speed_item_t it;
    logic nxt_valid;
    if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        send_gap = int'($urandom_range(1, 6)) - 1;
      end else if (speed_q.size() != 0) begin
        it = speed_q.pop_front();
        in_measured_speed <= it.meas;
        in_target_speed <= it.targ;
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request.
  always @(negedge clk) begin : drive_stall
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      recv_gap = int'($urandom_range(1, 6)) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check result items and predict for accepted input items.
  always @(posedge clk) begin : watch_ports
    cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (want_cmd_q.size() == 0) begin
        $display("%0t: unexpected result item, accel_cmd %0d brake_cmd %0d",
                 $time, out_accel_cmd, out_brake_cmd);
        fail_cnt++;
      end else begin
        want = want_cmd_q.pop_front();
        if (out_accel_cmd !== want.accel) begin
          $display("%0t: accel_cmd mismatch, expected %0d, actual %0d",
                   $time, want.accel, out_accel_cmd);
          fail_cnt++;
        end
        if (out_brake_cmd !== want.brake) begin
          $display("%0t: brake_cmd mismatch, expected %0d, actual %0d",
                   $time, want.brake, out_brake_cmd);
          fail_cnt++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want_cmd_q = {want_cmd_q, pid_predict(in_measured_speed, in_target_speed)};
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Main sequence: directed phases first, then random phases.
  initial begin : run_phases
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With reset gains every sum is zero, so only a zero brake comes out.
    add_item(-32768, 32767);
    add_item(32767, -32768);
    wait_idle();

    // Unity gains; full-scale errors drive the integral into both clamps.
    set_gains(16'sd256, 16'sd256, 16'sd256);
    write_gain(REG_UNUSED, 16'h7fff);
    add_item(-32768, 32767);
    add_item(-32768, 32767);
    add_item(32767, -32768);
    add_item(32767, -32768);
    add_item(0, 0);
    add_item(-1, 0);
    wait_idle();

    // Extreme gains of opposite signs.
    set_gains(16'sd32767, -16'sd32768, 16'sd32767);
    add_item(0, 32767);
    add_item(-32768, -32768);
    add_item(32767, 0);
    wait_idle();
    set_gains(-16'sd32768, 16'sd32767, -16'sd32768);
    add_item(-32768, 32767);
    add_item(0, 0);
    add_item(100, -100);
    wait_idle();

    // A tiny positive sum gives zero throttle; a zero sum gives zero brake.
    set_gains(16'sd1, 16'sd0, 16'sd0);
    add_item(0, 1);
    add_item(1, 0);
    add_item(5, 5);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) set_gains(16'sd32767, 16'sd32767, 16'sd32767);
      else if (ph == 1) set_gains(-16'sd32768, -16'sd32768, -16'sd32768);
      else set_gains(pick_gain(128), pick_gain(64), pick_gain(4));
      if (ph == RAND_PHASES - 1) no_idle = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) add_random_item();
      // The receiver holds off while the sender keeps offering items.
      if (ph == 3) hold_req = 1'b1;
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog in case the handshake hangs.
  initial begin : watchdog
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/spab_pkg.sv
rtl/spab_seq.sv
rtl/spab_dp.sv
rtl/speed_pid_accel_brake_core.sv
bench/speed_pid_accel_brake_core_tb.sv
